@@ rtl/mrpv_pkg.sv @@
package mrpv_pkg;

	localparam int STORE_DEPTH   = 4096;
	localparam int SAMPLE_BITS   = 12;
	localparam int FRAC_BITS     = 12;

	localparam int ADDR_BITS     = $clog2(STORE_DEPTH);
	localparam int ALEN_BITS     = ADDR_BITS + 1;
	localparam int PHASE_BITS    = ADDR_BITS + FRAC_BITS;
	localparam int STEP_BITS     = FRAC_BITS + 2;
	localparam int VOICES        = 6;
	localparam int VOICE_BITS    = $clog2(VOICES);

	localparam int MODE_BITS     = 4;
	localparam int DLEN_BITS     = 13;
	localparam int CFG_DATA_BITS = 32;
	localparam int CFG_ADDR_BITS = 3;

	// register map, selected by the top address bit
	localparam logic REG_MODE = 1'b0;
	localparam logic REG_LEN  = 1'b1;

	localparam logic [MODE_BITS-1:0] MODE_SINGLE_LO = MODE_BITS'(1);
	localparam logic [MODE_BITS-1:0] MODE_SINGLE_HI = MODE_BITS'(6);
	localparam logic [MODE_BITS-1:0] MODE_PAIR_BASE = MODE_BITS'(6);
	localparam logic [MODE_BITS-1:0] MODE_PAIR_LO   = MODE_BITS'(7);
	localparam logic [MODE_BITS-1:0] MODE_PAIR_HI   = MODE_BITS'(11);
	localparam logic [MODE_BITS-1:0] MODE_CASCADE   = MODE_BITS'(12);

	localparam logic [MODE_BITS-1:0] MODE_RESET = MODE_SINGLE_LO;
	localparam logic [DLEN_BITS-1:0] LEN_RESET  = DLEN_BITS'(4096);

	localparam logic [VOICE_BITS-1:0] LAST_VOICE    = VOICE_BITS'(VOICES - 1);
	localparam logic [VOICE_BITS-1:0] CASCADE_VOICE = VOICE_BITS'(4);

	// read steps, rounded half up to FRAC_BITS fraction bits
	localparam logic [STEP_BITS-1:0] STEP_1_0 =
		STEP_BITS'((longint'(1) << FRAC_BITS));
	localparam logic [STEP_BITS-1:0] STEP_1_25 =
		STEP_BITS'(((longint'(5) << FRAC_BITS) + 2) / 4);
	localparam logic [STEP_BITS-1:0] STEP_4_3 =
		STEP_BITS'(((longint'(13333) << FRAC_BITS) + 5000) / 10000);
	localparam logic [STEP_BITS-1:0] STEP_4_3_CASC =
		STEP_BITS'(((longint'(1333) << FRAC_BITS) + 500) / 1000);
	localparam logic [STEP_BITS-1:0] STEP_1_5 =
		STEP_BITS'(((longint'(3) << FRAC_BITS) + 1) / 2);
	localparam logic [STEP_BITS-1:0] STEP_5_3 =
		STEP_BITS'(((longint'(16666) << FRAC_BITS) + 5000) / 10000);
	localparam logic [STEP_BITS-1:0] STEP_2_0 =
		STEP_BITS'((longint'(2) << FRAC_BITS));

	// per-slot control carried down the voice pipeline
	typedef struct packed {
		logic [VOICE_BITS-1:0] voice;
		logic [MODE_BITS-1:0]  mode;
		logic                  wrapped;
		logic [ALEN_BITS-1:0]  len;
	} slot_ctl_t;

endpackage

@@ rtl/multi_rate_pitch_voices.sv @@
// Delay-line pitch shifter with six read voices at fixed rate ratios.
// Input channel: sample_in with sample_valid/sample_stall; a transfer happens
// when valid is high and stall is low. Output channel: voice_out with
// voice_valid/voice_stall, one result per input sample.
// Configuration: APB port, voice_mode at address 0, delay_length at 4.
// Write registers only while no sample is in flight.
// Each accepted sample is written to the sample memory, then a six-slot
// sequencer walks the voices one per cycle: read phase memory, take the old
// integer index, read the sample memory there, write the advanced phase back.
// Throughput is set by the single phase memory port, visited once per voice;
// the next sample may enter in the last voice slot of the current one. With the
// output empty, a result passes the phase, sample memory and output queue registers.
// Reset: phases, write pointer and held output return to zero; the sample
// memory is not swept, a fill mark makes unwritten entries read as zero.
// A two-entry output queue lets the next sample enter while a result waits;
// sample_stall rises before the sequencer's last voice slot and when two results are owed.
module multi_rate_pitch_voices (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [mrpv_pkg::CFG_ADDR_BITS-1:0]  paddr,
	input  logic [mrpv_pkg::CFG_DATA_BITS-1:0]  pwdata,
	output logic [mrpv_pkg::CFG_DATA_BITS-1:0]  prdata,
	output logic                                pready,
	input  logic [mrpv_pkg::SAMPLE_BITS-1:0]    sample_in,
	input  logic                                sample_valid,
	output logic                                sample_stall,
	output logic [mrpv_pkg::SAMPLE_BITS-1:0]    voice_out,
	output logic                                voice_valid,
	input  logic                                voice_stall
);
	import mrpv_pkg::*;

	localparam logic [1:0] OWED_MAX = 2'd2;

	logic [MODE_BITS-1:0]   mode;
	logic [ALEN_BITS-1:0]   len;
	logic                   wrapped;
	logic                   accept;
	logic                   can_take;
	logic                   out_xfer;
	logic [1:0]             owed_q;

	logic                   busy_q;
	logic [VOICE_BITS-1:0]  cnt_q;
	logic [MODE_BITS-1:0]   item_mode_q;
	logic                   item_wrap_q;
	logic [ALEN_BITS-1:0]   item_len_q;

	slot_ctl_t              ctl_s0;
	slot_ctl_t              ctl_s1;
	slot_ctl_t              ctl_s2;
	logic                   s1_v_q;
	logic                   s2_v_q;

	logic [ADDR_BITS-1:0]   idx;
	logic [SAMPLE_BITS-1:0] rd_data;
	logic                   rd_hit;
	logic [SAMPLE_BITS-1:0] tap;
	logic [SAMPLE_BITS-1:0] tap_q [VOICES-1];
	logic [SAMPLE_BITS-1:0] taps  [VOICES];

	logic                   push;
	logic                   single;
	logic                   pair;
	logic                   held;
	logic [VOICE_BITS-1:0]  sel;
	logic [SAMPLE_BITS:0]   sum_a;
	logic [SAMPLE_BITS:0]   sum_b;
	logic [SAMPLE_BITS:0]   sum_c;
	logic [SAMPLE_BITS-1:0] mix;
	logic [SAMPLE_BITS-1:0] result;
	logic [SAMPLE_BITS-1:0] held_q;

	mrpv_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.mode    (mode),
		.len     (len)
	);

	// next sample may enter in the last voice slot of the current one
	assign can_take     = (!busy_q || (cnt_q == LAST_VOICE)) && (owed_q < OWED_MAX);
	assign sample_stall = !can_take;
	assign accept       = sample_valid && can_take;
	assign out_xfer     = voice_valid && !voice_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			owed_q <= '0;
			s1_v_q <= 1'b0;
			s2_v_q <= 1'b0;
		end else begin
			owed_q <= owed_q + 2'(accept) - 2'(out_xfer);
			if (accept) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == LAST_VOICE)
					busy_q <= 1'b0;
				else
					cnt_q <= cnt_q + VOICE_BITS'(1);
			end
			s1_v_q <= busy_q;
			s2_v_q <= s1_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_mode_q <= mode;
			item_wrap_q <= wrapped;
			item_len_q  <= len;
		end
		ctl_s1 <= ctl_s0;
		ctl_s2 <= ctl_s1;
		if (s2_v_q && (ctl_s2.voice != LAST_VOICE))
			tap_q[ctl_s2.voice] <= tap;
	end

	always_comb begin
		ctl_s0.voice   = cnt_q;
		ctl_s0.mode    = item_mode_q;
		ctl_s0.wrapped = item_wrap_q;
		ctl_s0.len     = item_len_q;
	end

	mrpv_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_take (accept),
		.sample  (sample_in),
		.len     (len),
		.wrapped (wrapped),
		.rd_en   (s1_v_q),
		.rd_addr (idx),
		.rd_data (rd_data),
		.rd_hit  (rd_hit)
	);

	mrpv_phase u_phase (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (busy_q),
		.rd_voice (cnt_q),
		.wb_en    (s1_v_q),
		.ctl      (ctl_s1),
		.idx      (idx)
	);

	assign tap = rd_hit ? rd_data : '0;

	always_comb begin
		for (int i = 0; i < VOICES - 1; i++)
			taps[i] = tap_q[i];
		taps[VOICES-1] = tap;
	end

	// mixing happens in the last voice slot of a sample
	assign push   = s2_v_q && (ctl_s2.voice == LAST_VOICE);
	assign single = ctl_s2.mode inside {[MODE_SINGLE_LO:MODE_SINGLE_HI]};
	assign pair   = ctl_s2.mode inside {[MODE_PAIR_LO:MODE_PAIR_HI]};
	assign held   = (single && ctl_s2.wrapped) ||
		!(single || pair || (ctl_s2.mode == MODE_CASCADE));
	assign sel    = single ? VOICE_BITS'(ctl_s2.mode - MODE_SINGLE_LO)
		: VOICE_BITS'(ctl_s2.mode - MODE_PAIR_BASE);

	always_comb begin
		sum_a = '0;
		sum_b = '0;
		sum_c = '0;
		if (single) begin
			mix = taps[sel];
		end else if (pair) begin
			sum_a = {1'b0, taps[0]} + {1'b0, taps[sel]};
			mix   = sum_a[SAMPLE_BITS:1];
		end else begin
			sum_a = {1'b0, taps[3]} + {1'b0, taps[4]};
			sum_b = {1'b0, sum_a[SAMPLE_BITS:1]} + {1'b0, taps[0]};
			sum_c = {1'b0, sum_b[SAMPLE_BITS:1]} + {1'b0, taps[2]};
			mix   = sum_c[SAMPLE_BITS:1];
		end
		result = held ? held_q : mix;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			held_q <= '0;
		else if (push)
			held_q <= result;
	end

	mrpv_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (result),
		.valid  (voice_valid),
		.stall  (voice_stall),
		.dout   (voice_out)
	);

endmodule

@@ rtl/mrpv_regs.sv @@
module mrpv_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [mrpv_pkg::CFG_ADDR_BITS-1:0]  paddr,
	input  logic [mrpv_pkg::CFG_DATA_BITS-1:0]  pwdata,
	output logic [mrpv_pkg::CFG_DATA_BITS-1:0]  prdata,
	output logic                                pready,
	output logic [mrpv_pkg::MODE_BITS-1:0]      mode,
	output logic [mrpv_pkg::ALEN_BITS-1:0]      len
);
	import mrpv_pkg::*;

	logic [MODE_BITS-1:0] mode_q;
	logic [DLEN_BITS-1:0] dlen_q;
	logic                 wr_en;
	logic                 sel;

	assign pready = 1'b1;
	assign sel    = paddr[CFG_ADDR_BITS-1];
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RESET;
			dlen_q <= LEN_RESET;
		end else if (wr_en) begin
			case (sel)
				REG_MODE: mode_q <= pwdata[MODE_BITS-1:0];
				REG_LEN:  dlen_q <= pwdata[DLEN_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (sel)
			REG_MODE: prdata = {{(CFG_DATA_BITS-MODE_BITS){1'b0}}, mode_q};
			REG_LEN:  prdata = {{(CFG_DATA_BITS-DLEN_BITS){1'b0}}, dlen_q};
			default:  prdata = '0;
		endcase
	end

	// zero acts as one, anything past the store acts as the full store
	always_comb begin
		if (dlen_q == '0)
			len = ALEN_BITS'(1);
		else if (int'(dlen_q) > STORE_DEPTH)
			len = ALEN_BITS'(STORE_DEPTH);
		else
			len = ALEN_BITS'(dlen_q);
	end

	assign mode = mode_q;

endmodule

@@ rtl/mrpv_store.sv @@
module mrpv_store (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_take,
	input  logic [mrpv_pkg::SAMPLE_BITS-1:0]  sample,
	input  logic [mrpv_pkg::ALEN_BITS-1:0]    len,
	output logic                              wrapped,
	input  logic                              rd_en,
	input  logic [mrpv_pkg::ADDR_BITS-1:0]    rd_addr,
	output logic [mrpv_pkg::SAMPLE_BITS-1:0]  rd_data,
	output logic                              rd_hit
);
	import mrpv_pkg::*;

	logic [SAMPLE_BITS-1:0] mem [STORE_DEPTH];
	logic [SAMPLE_BITS-1:0] rd_data_q;
	logic [SAMPLE_BITS-1:0] wr_data_q;
	logic [ADDR_BITS-1:0]   wr_addr_q;
	logic [ADDR_BITS-1:0]   wp_q;
	logic [ALEN_BITS-1:0]   wp_inc;
	logic [ALEN_BITS-1:0]   wr_next;
	logic [ALEN_BITS-1:0]   fill_q;
	logic                   wr_pend_q;
	logic                   rd_hit_q;

	assign wp_inc  = ALEN_BITS'(wp_q) + ALEN_BITS'(1);
	assign wrapped = wp_inc >= len;
	assign wr_next = ALEN_BITS'(wr_addr_q) + ALEN_BITS'(1);

	// writes always walk up from zero, so everything below fill_q has been written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			wr_pend_q <= 1'b0;
			fill_q    <= '0;
			rd_hit_q  <= 1'b0;
		end else begin
			wr_pend_q <= wr_take;
			if (wr_take)
				wp_q <= wrapped ? '0 : wp_inc[ADDR_BITS-1:0];
			if (wr_pend_q && (ALEN_BITS'(wr_addr_q) >= fill_q))
				fill_q <= wr_next;
			rd_hit_q <= rd_en && (ALEN_BITS'(rd_addr) < fill_q);
		end
	end

	// read-old on a same-cycle collision
	always_ff @(posedge clk) begin
		if (wr_take) begin
			wr_addr_q <= wp_q;
			wr_data_q <= sample;
		end
		if (wr_pend_q)
			mem[wr_addr_q] <= wr_data_q;
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;
	assign rd_hit  = rd_hit_q;

endmodule

@@ rtl/mrpv_phase.sv @@
module mrpv_phase (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              rd_en,
	input  logic [mrpv_pkg::VOICE_BITS-1:0]   rd_voice,
	input  logic                              wb_en,
	input  mrpv_pkg::slot_ctl_t               ctl,
	output logic [mrpv_pkg::ADDR_BITS-1:0]    idx
);
	import mrpv_pkg::*;

	logic [PHASE_BITS-1:0] mem [VOICES];
	logic [VOICES-1:0]     vld_q;
	logic [PHASE_BITS-1:0] rd_data_q;
	logic                  rd_vld_q;
	logic [PHASE_BITS-1:0] phase;
	logic [PHASE_BITS:0]   sum;
	logic [PHASE_BITS:0]   limit;
	logic [PHASE_BITS-1:0] phase_nxt;
	logic [STEP_BITS-1:0]  step;
	logic                  adv;

	always_comb begin
		case (ctl.voice)
			VOICE_BITS'(0): step = STEP_1_0;
			VOICE_BITS'(1): step = STEP_1_25;
			VOICE_BITS'(2): step = (ctl.mode == MODE_CASCADE) ? STEP_4_3_CASC : STEP_4_3;
			VOICE_BITS'(3): step = STEP_1_5;
			VOICE_BITS'(4): step = STEP_5_3;
			default:        step = STEP_2_0;
		endcase
	end

	always_comb begin
		if (ctl.mode inside {[MODE_SINGLE_LO:MODE_SINGLE_HI]})
			adv = !ctl.wrapped &&
				(ctl.voice == VOICE_BITS'(ctl.mode - MODE_SINGLE_LO));
		else if (ctl.mode inside {[MODE_PAIR_LO:MODE_PAIR_HI]})
			adv = (ctl.voice == '0) ||
				(ctl.voice == VOICE_BITS'(ctl.mode - MODE_PAIR_BASE));
		else if (ctl.mode == MODE_CASCADE)
			adv = ctl.voice <= CASCADE_VOICE;
		else
			adv = 1'b0;
	end

	// a never-written entry reads as phase zero
	assign phase = rd_vld_q ? rd_data_q : '0;
	assign idx   = phase[PHASE_BITS-1:FRAC_BITS];
	assign sum   = {1'b0, phase} + (adv ? (PHASE_BITS+1)'(step) : '0);
	assign limit = {ctl.len, {FRAC_BITS{1'b0}}};

	// every voice gets its wrap check each sample, advanced or not
	assign phase_nxt = (sum >= limit) ? '0 : sum[PHASE_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (rd_en)
				rd_vld_q <= vld_q[rd_voice];
			if (wb_en)
				vld_q[ctl.voice] <= 1'b1;
		end
	end

	// read and write-back never hit the same voice in one cycle
	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data_q <= mem[rd_voice];
		if (wb_en)
			mem[ctl.voice] <= phase_nxt;
	end

endmodule

@@ rtl/mrpv_outq.sv @@
module mrpv_outq (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  logic [mrpv_pkg::SAMPLE_BITS-1:0]  din,
	output logic                              valid,
	input  logic                              stall,
	output logic [mrpv_pkg::SAMPLE_BITS-1:0]  dout
);
	import mrpv_pkg::*;

	logic [SAMPLE_BITS-1:0] head_q;
	logic [SAMPLE_BITS-1:0] tail_q;
	logic                   head_v_q;
	logic                   tail_v_q;
	logic                   pop;

	assign pop = head_v_q && !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			tail_v_q <= 1'b0;
		end else if (pop) begin
			if (tail_v_q) begin
				head_q <= tail_q;
				if (push)
					tail_q <= din;
				else
					tail_v_q <= 1'b0;
			end else begin
				head_v_q <= push;
				head_q   <= din;
			end
		end else if (push) begin
			if (!head_v_q) begin
				head_v_q <= 1'b1;
				head_q   <= din;
			end else begin
				tail_v_q <= 1'b1;
				tail_q   <= din;
			end
		end
	end

	assign valid = head_v_q;
	assign dout  = head_q;

endmodule

@@ rtl/mrpv_checker.sv @@
module mrpv_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                psel,
	input logic                                penable,
	input logic                                pwrite,
	input logic [mrpv_pkg::CFG_ADDR_BITS-1:0]  paddr,
	input logic [mrpv_pkg::CFG_DATA_BITS-1:0]  pwdata,
	input logic [mrpv_pkg::CFG_DATA_BITS-1:0]  prdata,
	input logic                                pready,
	input logic [mrpv_pkg::SAMPLE_BITS-1:0]    sample_in,
	input logic                                sample_valid,
	input logic                                sample_stall,
	input logic [mrpv_pkg::SAMPLE_BITS-1:0]    voice_out,
	input logic                                voice_valid,
	input logic                                voice_stall
);
	import mrpv_pkg::*;

	// RESULT_LAT reaches from the input transfer to the edge that first samples valid high
	localparam int RESULT_LAT = 9;

	// a stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		voice_valid && voice_stall |=> voice_valid && $stable(voice_out))
		else $error("voice_out changed while stalled");

	// the voice sequencer holds off the next sample for the rest of its slots
	a_in_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall |=> sample_stall)
		else $error("sample taken in back-to-back cycles");

	// a fresh result on an empty output comes from a transfer a fixed time ago
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(voice_valid) |-> $past(sample_valid && !sample_stall, RESULT_LAT))
		else $error("result without matching input transfer");

	// mode register reads back what was written
	a_mode_rb: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready &&
		(paddr[CFG_ADDR_BITS-1] == REG_MODE)
		|=> (paddr[CFG_ADDR_BITS-1] != REG_MODE) ||
		(prdata[MODE_BITS-1:0] == $past(pwdata[MODE_BITS-1:0])))
		else $error("voice_mode readback mismatch");

endmodule

bind multi_rate_pitch_voices mrpv_checker u_mrpv_checker (.*);

@@ bench/tb_multi_rate_pitch_voices.sv @@
module tb_multi_rate_pitch_voices;
	timeunit 1ns;
	timeprecision 1ps;

	import mrpv_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int LONG_HOLD   = 300;
	localparam int SETTLE_CYC  = 16;
	localparam int RAND_SETS   = 26;
	localparam int SET_ITEMS   = 48;

	// Q2.12 read rates: 1, 1.25, 1.3333, 1.5, 1.6666, 2; cascade uses 1.333
	localparam int RATE_STEP [VOICES] = '{4096, 5120, 5461, 6144, 6826, 8192};
	localparam int CASC_STEP = 5460;

	localparam logic [SAMPLE_BITS-1:0] CORNER_VALS [7] =
		'{12'h000, 12'hFFF, 12'hAAA, 12'h555, 12'h001, 12'h800, 12'hFFE};

	class voice_board;
		logic [SAMPLE_BITS-1:0]  store [STORE_DEPTH];
		logic [ADDR_BITS-1:0]    wr_pos;
		logic [PHASE_BITS+1:0]   phase [VOICES];
		logic [ADDR_BITS-1:0]    rd_idx [VOICES];
		logic [SAMPLE_BITS-1:0]  held;
		logic [MODE_BITS-1:0]    mode;
		logic [DLEN_BITS-1:0]    dlen;
		logic [SAMPLE_BITS-1:0]  pending [$];
		int                      errors;

		function new();
			foreach (store[i]) store[i] = '0;
			foreach (phase[i]) begin
				phase[i] = '0;
				rd_idx[i] = '0;
			end
			wr_pos = '0;
			held = '0;
			mode = MODE_RESET;
			dlen = LEN_RESET;
			errors = 0;
		endfunction

		task report(input string msg);
			$display("[%0t] mismatch: %s", $realtime, msg);
			errors++;
		endtask

		function void write_reg(input logic which, input logic [CFG_DATA_BITS-1:0] value);
			if (which == REG_MODE)
				mode = value[MODE_BITS-1:0];
			else
				dlen = value[DLEN_BITS-1:0];
		endfunction

		function logic [SAMPLE_BITS:0] tap(input int v);
			return {1'b0, store[rd_idx[v]]};
		endfunction

		function void advance(input int v, input int stp);
			phase[v] = phase[v] + (PHASE_BITS+2)'(stp);
		endfunction

		// one accepted sample: write, advance the selected voices, mix
		function void note_sample(input logic [SAMPLE_BITS-1:0] s);
			logic [ALEN_BITS-1:0]  alen;
			logic [ALEN_BITS-1:0]  w;
			logic                  wrapped;
			logic [PHASE_BITS+1:0] limit;
			logic [SAMPLE_BITS:0]  mix;
			int                    k;
			if (dlen == '0)
				alen = ALEN_BITS'(1);
			else if (dlen > DLEN_BITS'(STORE_DEPTH))
				alen = ALEN_BITS'(STORE_DEPTH);
			else
				alen = ALEN_BITS'(dlen);
			store[wr_pos] = s;
			w = {1'b0, wr_pos} + ALEN_BITS'(1);
			wrapped = (w >= alen);
			if (wrapped)
				w = '0;
			wr_pos = w[ADDR_BITS-1:0];
			if (mode >= MODE_SINGLE_LO && mode <= MODE_SINGLE_HI) begin
				if (!wrapped) begin
					k = int'(mode) - 1;
					advance(k, RATE_STEP[k]);
					mix = tap(k);
					held = mix[SAMPLE_BITS-1:0];
				end
			end else if (mode >= MODE_PAIR_LO && mode <= MODE_PAIR_HI) begin
				k = int'(mode) - int'(MODE_PAIR_BASE);
				advance(0, RATE_STEP[0]);
				advance(k, RATE_STEP[k]);
				mix = (tap(0) + tap(k)) >> 1;
				held = mix[SAMPLE_BITS-1:0];
			end else if (mode == MODE_CASCADE) begin
				advance(0, RATE_STEP[0]);
				advance(1, RATE_STEP[1]);
				advance(2, CASC_STEP);
				advance(3, RATE_STEP[3]);
				advance(4, RATE_STEP[4]);
				mix = (tap(3) + tap(4)) >> 1;
				mix = (mix + tap(0)) >> 1;
				mix = (mix + tap(2)) >> 1;
				held = mix[SAMPLE_BITS-1:0];
			end
			// stale or overrun phases fall back to zero on every sample
			limit = (PHASE_BITS+2)'(alen) << FRAC_BITS;
			for (int v = 0; v < VOICES; v++) begin
				if (phase[v] >= limit)
					phase[v] = '0;
				rd_idx[v] = phase[v][FRAC_BITS +: ADDR_BITS];
			end
			pending.push_back(held);
		endfunction

		task check_voice(input logic [SAMPLE_BITS-1:0] got);
			logic [SAMPLE_BITS-1:0] want;
			if (pending.size() == 0) begin
				report($sformatf("voice_out %03h with nothing outstanding", got));
			end else begin
				want = pending.pop_front();
				if (got !== want)
					report($sformatf("voice_out %03h, predicted %03h", got, want));
			end
		endtask
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      psel;
	logic                      penable;
	logic                      pwrite;
	logic [CFG_ADDR_BITS-1:0]  paddr;
	logic [CFG_DATA_BITS-1:0]  pwdata;
	logic [CFG_DATA_BITS-1:0]  prdata;
	logic                      pready;
	logic [SAMPLE_BITS-1:0]    sample_in;
	logic                      sample_valid;
	logic                      sample_stall;
	logic [SAMPLE_BITS-1:0]    voice_out;
	logic                      voice_valid;
	logic                      voice_stall;

	voice_board board;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_requests;
	int holds_done;
	int hold_left;
	int cycles;

	multi_rate_pitch_voices uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.sample_in    (sample_in),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.voice_out    (voice_out),
		.voice_valid  (voice_valid),
		.voice_stall  (voice_stall)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// result side: check transfers, then pick the next stall value
	initial begin
		voice_stall <= 1'b0;
		holds_done = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && voice_valid && !voice_stall)
				board.check_voice(voice_out);
			if (holds_done < hold_requests) begin
				holds_done++;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				voice_stall <= 1'b1;
			end else begin
				voice_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	task automatic cfg_write(input logic which, input logic [CFG_DATA_BITS-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {which, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		board.write_reg(which, value);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_sample(input logic [SAMPLE_BITS-1:0] s);
		if ($urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		sample_valid <= 1'b1;
		sample_in    <= s;
		do @(posedge clk); while (sample_stall);
		board.note_sample(s);
	endtask

	task automatic play_samples(input int count, input bit fixed);
		logic [SAMPLE_BITS-1:0] s;
		for (int i = 0; i < count; i++) begin
			if (fixed)
				s = CORNER_VALS[i % 7];
			else if ($urandom_range(15) == 0)
				s = $urandom_range(1) ? '1 : '0;
			else
				s = SAMPLE_BITS'($urandom_range(4095));
			send_sample(s);
		end
		sample_valid <= 1'b0;
	endtask

	// wait for every owed result, then let the voice sequencer finish
	task automatic settle();
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic run_setting(input logic [CFG_DATA_BITS-1:0] mode_word,
			input logic [CFG_DATA_BITS-1:0] len_word, input int count, input bit fixed);
		cfg_write(REG_MODE, mode_word);
		cfg_write(REG_LEN, len_word);
		play_samples(count, fixed);
		settle();
	endtask

	initial begin
		logic [CFG_DATA_BITS-1:0] mode_word;
		logic [CFG_DATA_BITS-1:0] len_word;
		logic [DLEN_BITS-1:0]     len;
		board = new();
		cycles = 0;
		hold_requests = 0;
		send_idle_pct = 9;
		recv_idle_pct = 61;
		arst_n       <= 1'b0;
		psel         <= 1'b0;
		penable      <= 1'b0;
		pwrite       <= 1'b0;
		paddr        <= '0;
		pwdata       <= '0;
		sample_in    <= '0;
		sample_valid <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings first, then corners: wrap hold, length one,
		// length zero and oversized, unused modes
		play_samples(4, 1'b1);
		settle();
		run_setting(32'd6, 32'd3, 4, 1'b1);
		run_setting(32'(MODE_CASCADE), 32'd1, 3, 1'b1);
		run_setting(32'd0, 32'd0, 2, 1'b1);
		run_setting(32'(MODE_PAIR_HI), 32'd8191, 3, 1'b1);
		run_setting(32'd15, 32'd2, 2, 1'b1);
		run_setting(32'd13, 32'd5, 2, 1'b1);
		run_setting(32'(MODE_PAIR_LO), 32'd4096, 3, 1'b1);

		for (int ph = 0; ph < RAND_SETS; ph++) begin
			if (ph < 9) begin
				send_idle_pct = 9;
				recv_idle_pct = 61;
			end else if (ph < 18) begin
				send_idle_pct = 61;
				recv_idle_pct = 9;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			case ($urandom_range(9))
				0:       len = DLEN_BITS'(1);
				1:       len = DLEN_BITS'($urandom_range(8, 2));
				2, 3:    len = DLEN_BITS'($urandom_range(64, 9));
				4, 5:    len = DLEN_BITS'($urandom_range(700, 65));
				6:       len = DLEN_BITS'(4096);
				7:       len = DLEN_BITS'(4095);
				8:       len = '0;
				default: len = DLEN_BITS'($urandom_range(8191, 4097));
			endcase
			mode_word = $urandom;
			len_word  = $urandom;
			if (ph < 24)
				mode_word[MODE_BITS-1:0] = MODE_BITS'((ph % 12) + 1);
			else
				mode_word[MODE_BITS-1:0] = MODE_BITS'($urandom_range(15));
			len_word[DLEN_BITS-1:0] = len;
			if (ph == 4 || ph == 20)
				hold_requests++;
			run_setting(mode_word, len_word, SET_ITEMS, 1'b0);
		end

		settle();
		if (board.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ multi_rate_pitch_voices.f @@
rtl/mrpv_pkg.sv
rtl/mrpv_regs.sv
rtl/mrpv_store.sv
rtl/mrpv_phase.sv
rtl/mrpv_outq.sv
rtl/multi_rate_pitch_voices.sv
rtl/mrpv_checker.sv
bench/tb_multi_rate_pitch_voices.sv
